/* hdl/vertex_dedup_hash_table_core_macros.svh */
// Assertion macros shared by the vertex deduplication RTL.
`ifndef VERTEX_DEDUP_HASH_TABLE_CORE_MACROS_SVH
`define VERTEX_DEDUP_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define VDH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vdh check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define VDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vdh check failed");

`endif

/* hdl/vdh_pkg.sv */
// Shared constants for the vertex deduplication hash table.
package vdh_pkg;
  localparam int COMP_W          = 32;
  localparam int NUM_COMP_PORTS  = 8;
  localparam int NEW_INDEX_W     = 12;
  localparam int COUNT_W         = 13;
  localparam int CCOUNT_W        = 4;
  localparam int GEN_W           = 8;
  localparam int MAX_UNIQUE_DEF     = 4096;
  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int HASH_SLOTS_DEF     = 8192;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 4'd8;
  localparam logic [COMP_W-1:0]   HASH_PRIME   = 32'h0100_0193;
endpackage

/* hdl/vdh_if.sv */
// Handshake channels of the vertex deduplication block.
interface vdh_in_if;
  import vdh_pkg::*;
  logic valid;
  logic ready;
  logic first_of_mesh;
  logic signed [COMP_W-1:0] comp_0;
  logic signed [COMP_W-1:0] comp_1;
  logic signed [COMP_W-1:0] comp_2;
  logic signed [COMP_W-1:0] comp_3;
  logic signed [COMP_W-1:0] comp_4;
  logic signed [COMP_W-1:0] comp_5;
  logic signed [COMP_W-1:0] comp_6;
  logic signed [COMP_W-1:0] comp_7;
  modport source (output valid, first_of_mesh, comp_0, comp_1, comp_2, comp_3,
                  comp_4, comp_5, comp_6, comp_7, input ready);
  modport sink (input valid, first_of_mesh, comp_0, comp_1, comp_2, comp_3,
                comp_4, comp_5, comp_6, comp_7, output ready);
endinterface

interface vdh_out_if;
  import vdh_pkg::*;
  logic valid;
  logic ready;
  logic [NEW_INDEX_W-1:0] new_index;
  logic                   first_seen;
  logic [COUNT_W-1:0]     unique_count;
  logic                   overflow;
  modport source (output valid, new_index, first_seen, unique_count, overflow,
                  input ready);
  modport sink (input valid, new_index, first_seen, unique_count, overflow,
                output ready);
endinterface

interface vdh_cfg_if;
  import vdh_pkg::*;
  logic valid;
  logic ready;
  logic [CCOUNT_W-1:0] component_count;
  modport source (output valid, component_count, input ready);
  modport sink (input valid, component_count, output ready);
endinterface

/* hdl/vdh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule

/* hdl/vdh_hash.sv */
// Three-stage hash of the masked vertex onto a starting slot.
module vdh_hash #(
  parameter int MAX_COMPONENTS = vdh_pkg::MAX_COMPONENTS_DEF,
  parameter int HASH_SLOTS     = vdh_pkg::HASH_SLOTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [MAX_COMPONENTS*vdh_pkg::COMP_W-1:0] comps,
  output logic [$clog2(HASH_SLOTS)-1:0]           slot_r,
  output logic                                    done_r
);
  import vdh_pkg::*;
  localparam int SW = $clog2(HASH_SLOTS);

  logic [COMP_W-1:0] fold;
  logic [COMP_W-1:0] fold_r;
  logic [COMP_W-1:0] mix_r;
  logic [COMP_W-1:0] spread;
  logic [2*COMP_W-1:0] scaled;
  logic v1_r;
  logic v2_r;

  // Fold the components together, each rotated by its own amount.
  always_comb begin
    logic [COMP_W-1:0] c;
    fold = '0;
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      c = comps[i*COMP_W +: COMP_W];
      fold = fold ^ ((c << ((7 * i) % COMP_W)) | (c >> ((COMP_W - (7 * i) % COMP_W) % COMP_W)));
    end
  end

  // Range-map the mixed word onto the slot count with a high multiply.
  assign spread = mix_r ^ (mix_r >> 15);
  assign scaled = {{COMP_W{1'b0}}, spread} * (2*COMP_W)'(HASH_SLOTS);

  // The folded word is captured with the item and held, so the slot stays
  // valid for as long as the sequencer needs it.
  always_ff @(posedge clk) begin
    if (start) begin
      fold_r <= fold;
    end
    mix_r  <= fold_r * HASH_PRIME;
    slot_r <= SW'(scaled >> COMP_W);
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      if (start) begin
        done_r <= 1'b0;
      end else if (v2_r) begin
        done_r <= 1'b1;
      end
    end
  end
endmodule

/* hdl/vertex_dedup_hash_table_core.sv */
// Vertex deduplication hash table: one vertex in, its unique index out. An item
// passes through the hash pipeline, a slot-table read, a slot check, a
// vertex-store compare when the slot is occupied, and the result register; each
// further slot on the probe chain repeats the read, the check and the compare. A
// new item is taken only once the last one has left for the result register.
// Clearing the table (a first_of_mesh item or any component_count write) is done
// by bumping a generation mark held in every slot; after reset, and on every
// 255th clear, a sweep writes all HASH_SLOTS slots, one per cycle, during which
// no item is taken. Configuration writes are taken in any cycle.
module vertex_dedup_hash_table_core #(
  parameter int MAX_UNIQUE     = vdh_pkg::MAX_UNIQUE_DEF,
  parameter int MAX_COMPONENTS = vdh_pkg::MAX_COMPONENTS_DEF,
  parameter int HASH_SLOTS     = vdh_pkg::HASH_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  vdh_in_if.sink    in_ch,
  vdh_out_if.source out_ch,
  vdh_cfg_if.sink   cfg_ch
);
  import vdh_pkg::*;
  `include "vertex_dedup_hash_table_core_macros.svh"

  localparam int IW  = $clog2(MAX_UNIQUE);
  localparam int CW  = $clog2(MAX_UNIQUE + 1);
  localparam int SW  = $clog2(HASH_SLOTS);
  localparam int PW  = $clog2(HASH_SLOTS + 1);
  localparam int RW  = MAX_COMPONENTS * COMP_W;
  localparam int EW  = GEN_W + IW;
  localparam int CAP = (MAX_UNIQUE < HASH_SLOTS) ? MAX_UNIQUE : HASH_SLOTS;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_HASH, ST_RD, ST_CHK, ST_VCHK, ST_OUT
  } state_t;

  state_t              state_r;
  logic [CCOUNT_W-1:0] ccount_r;
  logic [CW-1:0]       count_r;
  logic [GEN_W-1:0]    gen_r;
  logic [SW-1:0]       sweep_r;
  logic                resume_r;
  logic [RW-1:0]       comps_r;
  logic [SW-1:0]       probe_r;
  logic [PW-1:0]       tries_r;
  logic [IW-1:0]       res_idx_r;
  logic                res_first_r;
  logic                res_ovf_r;
  logic                out_valid_r;
  logic [NEW_INDEX_W-1:0] out_idx_r;
  logic                out_first_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_ovf_r;

  logic [CCOUNT_W-1:0] n_eff;
  logic [COMP_W-1:0]   in_comp [NUM_COMP_PORTS];
  logic [RW-1:0]       masked;
  logic                accept;
  logic                cfg_wr;
  logic                hash_done;
  logic [SW-1:0]       hash_slot;
  logic                slot_we;
  logic [SW-1:0]       slot_waddr;
  logic [EW-1:0]       slot_wdata;
  logic [EW-1:0]       slot_rdata;
  logic [RW-1:0]       vert_rdata;
  logic                occupied;
  logic [IW-1:0]       slot_idx;
  logic                room;
  logic                insert;
  logic                gen_full;
  logic [SW-1:0]       probe_next;

  // Components in use: zero acts as one, large values saturate.
  always_comb begin
    if (ccount_r == '0) begin
      n_eff = CCOUNT_W'(1);
    end else if (ccount_r > CCOUNT_W'(MAX_COMPONENTS)) begin
      n_eff = CCOUNT_W'(MAX_COMPONENTS);
    end else begin
      n_eff = ccount_r;
    end
  end

  assign in_comp[0] = in_ch.comp_0;
  assign in_comp[1] = in_ch.comp_1;
  assign in_comp[2] = in_ch.comp_2;
  assign in_comp[3] = in_ch.comp_3;
  assign in_comp[4] = in_ch.comp_4;
  assign in_comp[5] = in_ch.comp_5;
  assign in_comp[6] = in_ch.comp_6;
  assign in_comp[7] = in_ch.comp_7;

  // Unused components are zeroed so that compare and hash ignore them.
  always_comb begin
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      masked[i*COMP_W +: COMP_W] = (i < int'(n_eff)) ? in_comp[i] : '0;
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = cfg_ch.valid;
  assign gen_full     = (gen_r == {GEN_W{1'b1}});

  vdh_hash #(
    .MAX_COMPONENTS(MAX_COMPONENTS),
    .HASH_SLOTS    (HASH_SLOTS)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .comps (masked),
    .slot_r(hash_slot),
    .done_r(hash_done)
  );

  // A slot is live only when it carries the current generation.
  assign occupied   = (slot_rdata[EW-1 -: GEN_W] == gen_r);
  assign slot_idx   = slot_rdata[IW-1:0];
  assign room       = (count_r < CW'(CAP));
  assign insert     = (state_r == ST_CHK) && !occupied && room;
  assign probe_next = (probe_r == SW'(HASH_SLOTS - 1)) ? '0 : probe_r + 1'b1;

  // Slot table write: sweep pattern or a newly inserted entry.
  always_comb begin
    slot_we    = insert || (state_r == ST_SWEEP);
    slot_waddr = (state_r == ST_SWEEP) ? sweep_r : probe_r;
    slot_wdata = (state_r == ST_SWEEP) ? '0 : {gen_r, IW'(count_r)};
  end

  vdh_ram #(.WIDTH(EW), .DEPTH(HASH_SLOTS)) u_slot_ram (
    .clk    (clk),
    .we     (slot_we),
    .waddr  (slot_waddr),
    .wdata  (slot_wdata),
    .raddr  (probe_r),
    .rdata_r(slot_rdata)
  );

  vdh_ram #(.WIDTH(RW), .DEPTH(MAX_UNIQUE)) u_vert_ram (
    .clk    (clk),
    .we     (insert),
    .waddr  (IW'(count_r)),
    .wdata  (comps_r),
    .raddr  (slot_idx),
    .rdata_r(vert_rdata)
  );

  // Sequencer: state, table bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      ccount_r    <= CCOUNT_RESET;
      count_r     <= '0;
      gen_r       <= '0;
      sweep_r     <= '0;
      resume_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result loads it.
      if (out_ch.ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        ccount_r <= cfg_ch.component_count;
        count_r  <= '0;
        if (state_r != ST_SWEEP) begin
          if (gen_full) begin
            state_r  <= ST_SWEEP;
            sweep_r  <= '0;
            resume_r <= 1'b0;
          end else begin
            gen_r <= gen_r + 1'b1;
          end
        end
      end
      unique case (state_r)
        ST_SWEEP: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == SW'(HASH_SLOTS - 1)) begin
            gen_r   <= GEN_W'(1);
            state_r <= resume_r ? ST_HASH : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            comps_r <= masked;
            if (in_ch.first_of_mesh) begin
              count_r <= '0;
              if (gen_full) begin
                state_r  <= ST_SWEEP;
                sweep_r  <= '0;
                resume_r <= 1'b1;
              end else begin
                gen_r   <= gen_r + 1'b1;
                state_r <= ST_HASH;
              end
            end else begin
              state_r <= ST_HASH;
            end
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            probe_r <= hash_slot;
            tries_r <= '0;
            state_r <= ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (occupied) begin
            state_r <= ST_VCHK;
          end else begin
            res_first_r <= room;
            res_ovf_r   <= !room;
            res_idx_r   <= room ? IW'(count_r) : '0;
            if (room) begin
              count_r <= count_r + 1'b1;
            end
            state_r <= ST_OUT;
          end
        end
        ST_VCHK: begin
          if (vert_rdata == comps_r) begin
            res_first_r <= 1'b0;
            res_ovf_r   <= 1'b0;
            res_idx_r   <= slot_idx;
            state_r     <= ST_OUT;
          end else if (tries_r == PW'(HASH_SLOTS - 1)) begin
            res_first_r <= 1'b0;
            res_ovf_r   <= 1'b1;
            res_idx_r   <= '0;
            state_r     <= ST_OUT;
          end else begin
            tries_r <= tries_r + 1'b1;
            probe_r <= probe_next;
            state_r <= ST_RD;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= NEW_INDEX_W'(res_idx_r);
            out_first_r <= res_first_r;
            out_count_r <= COUNT_W'(count_r);
            out_ovf_r   <= res_ovf_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.new_index    = out_idx_r;
  assign out_ch.first_seen   = out_first_r;
  assign out_ch.unique_count = out_count_r;
  assign out_ch.overflow     = out_ovf_r;

  // The table never holds more entries than its capacity.
  `VDH_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CW'(CAP))
  // Outside a sweep the live generation is never the swept-slot mark.
  `VDH_ASSERT_NOW(a_gen_live, state_r != ST_SWEEP && state_r != ST_IDLE, gen_r != '0)
  // An overflow result reports index zero and nothing newly stored.
  `VDH_ASSERT_NOW(a_ovf_result, out_valid_r && out_ovf_r, out_idx_r == '0 && !out_first_r)
  // Every insert advances the count by exactly one.
  `VDH_ASSERT_NEXT(a_insert_count, insert && !cfg_wr, count_r == $past(count_r) + 1'b1)
endmodule
